[hdl/tdmans_pkg.sv]
// ----------------------------------------------------------------------------
// tdmans_pkg: shared types and constants of the TDMA node slot scheduler
// Codes, register indexes, the configuration bundle, item and result types.
// ----------------------------------------------------------------------------
package tdmans_pkg;

  // Superframe limits
  localparam logic [4:0] MAX_SLOTS   = 5'd16;
  localparam logic [3:0] QUEUE_LIMIT = 4'd4;

  // Command codes
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_FRAME     = 2'd1;
  localparam logic [1:0] CMD_TX_RESULT = 2'd2;

  // Downlink frame types
  localparam logic [1:0] FT_BEACON = 2'd0;
  localparam logic [1:0] FT_ASSIGN = 2'd1;

  // Transmit request kinds
  localparam logic [1:0] TX_NONE      = 2'd0;
  localparam logic [1:0] TX_HEARTBEAT = 2'd1;
  localparam logic [1:0] TX_JOIN      = 2'd2;

  // Special index values
  localparam logic [7:0] SLOT_NONE      = 8'hFF;
  localparam logic [7:0] DEST_BROADCAST = 8'hFF;

  // Configuration register indexes
  localparam logic [2:0] REG_BEACON_TIME   = 3'd0;
  localparam logic [2:0] REG_DOWNLINK_TIME = 3'd1;
  localparam logic [2:0] REG_SLOT_TIME     = 3'd2;
  localparam logic [2:0] REG_TAIL_TIME     = 3'd3;
  localparam logic [2:0] REG_HB_PERIOD     = 3'd4;
  localparam logic [2:0] REG_BEACON_LOST   = 3'd5;
  localparam logic [2:0] REG_OWN_INDEX     = 3'd6;
  localparam logic [2:0] REG_JOIN_EVERY    = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef struct packed {
    logic [19:0] beacon_time_us;
    logic [19:0] downlink_time_us;
    logic [19:0] slot_time_us;
    logic [19:0] tail_time_us;
    logic [15:0] heartbeat_period_ms;
    logic [15:0] beacon_lost_ms;
    logic [7:0]  own_index;
    logic [7:0]  join_every;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic        frame_ok;
    logic [1:0]  frame_type;
    logic [7:0]  dest_index;
    logic [31:0] payload_word;
    logic [7:0]  payload_last;
    logic [31:0] start_us;
    logic [15:0] jitter_us;
    logic        tx_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]  tx_kind;
    logic [31:0] tx_at_us;
    logic        is_locked;
    logic        is_assigned;
    logic [7:0]  slot_number;
    logic [4:0]  slots_in_frame;
    logic        rescan_request;
    logic [31:0] superframe_count;
  } result_t;

endpackage

[hdl/tdmans_cfg.sv]
// ----------------------------------------------------------------------------
// tdmans_cfg: configuration register file
// Write-only registers, loaded by index from the plain write port.
// ----------------------------------------------------------------------------
module tdmans_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tdmans_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tdmans_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output tdmans_pkg::cfg_t                    cfg_o
);

  tdmans_pkg::cfg_t cfg_q;

  // Register writes, low bits of the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beacon_time_us      <= 20'd0;
      cfg_q.downlink_time_us    <= 20'd0;
      cfg_q.slot_time_us        <= 20'd1;
      cfg_q.tail_time_us        <= 20'd0;
      cfg_q.heartbeat_period_ms <= 16'd1000;
      cfg_q.beacon_lost_ms      <= 16'd3000;
      cfg_q.own_index           <= 8'd0;
      cfg_q.join_every          <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdmans_pkg::REG_BEACON_TIME:   cfg_q.beacon_time_us      <= cfg_wdata_i;
        tdmans_pkg::REG_DOWNLINK_TIME: cfg_q.downlink_time_us    <= cfg_wdata_i;
        tdmans_pkg::REG_SLOT_TIME:     cfg_q.slot_time_us        <= cfg_wdata_i;
        tdmans_pkg::REG_TAIL_TIME:     cfg_q.tail_time_us        <= cfg_wdata_i;
        tdmans_pkg::REG_HB_PERIOD:     cfg_q.heartbeat_period_ms <= cfg_wdata_i[15:0];
        tdmans_pkg::REG_BEACON_LOST:   cfg_q.beacon_lost_ms      <= cfg_wdata_i[15:0];
        tdmans_pkg::REG_OWN_INDEX:     cfg_q.own_index           <= cfg_wdata_i[7:0];
        tdmans_pkg::REG_JOIN_EVERY:    cfg_q.join_every          <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/tdmans_jdiv.sv]
// ----------------------------------------------------------------------------
// tdmans_jdiv: serial remainder unit for the join spacing
// Restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdmans_jdiv (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       busy_o,
  output logic       done_o,
  output logic [7:0] rem_o
);

  logic       busy_q;
  logic [2:0] cnt_q;
  logic [7:0] rem_q, rem_d;
  logic [7:0] sh_q;
  logic [7:0] div_q;
  logic [8:0] trial;

  // One restoring step
  always_comb begin
    trial = {rem_q, sh_q[7]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = 8'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath; a zero divisor acts as one
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 8'd0;
      sh_q  <= dividend_i;
      div_q <= (divisor_i == 8'd0) ? 8'd1 : divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[6:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == 3'd7);
  assign rem_o  = rem_d;

endmodule

[hdl/tdmans_core.sv]
// ----------------------------------------------------------------------------
// tdmans_core: scheduler state and single-pass step logic
// Holds the lock, slot and queue state; computes one result per fired item.
// ----------------------------------------------------------------------------
module tdmans_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdmans_pkg::cfg_t          cfg_i,
  input  logic                      fire_i,
  input  tdmans_pkg::item_t         item_i,
  input  logic                      every_wr_i,
  input  logic [7:0]                every_val_i,
  output logic                      busy_o,
  output tdmans_pkg::result_t       res_o
);

  // State
  logic        locked_q, locked_d;
  logic        assigned_q, assigned_d;
  logic [31:0] phase_q, phase_d;
  logic [31:0] frame_cnt_q, frame_cnt_d;
  logic [4:0]  slot_total_q, slot_total_d;
  logic [7:0]  my_slot_q, my_slot_d;
  logic [2:0]  bmap_ver_q, bmap_ver_d;
  logic [7:0]  held_ver_q, held_ver_d;
  logic        slot_sent_q, slot_sent_d;
  logic        join_sent_q, join_sent_d;
  logic        join_due_q, join_due_d;
  logic [7:0]  join_seq_q, join_seq_d;
  logic [7:0]  join_res_q, join_res_d;
  logic [15:0] jitter_q, jitter_d;
  logic [3:0]  pend_q, pend_d;
  logic [31:0] last_enq_q, last_enq_d;
  logic [31:0] last_bcn_q, last_bcn_d;

  // Step temporaries
  logic [1:0]  kind;
  logic [31:0] at_us;
  logic        rescan;
  logic        requested;
  logic [4:0]  n_slots;
  logic [7:0]  every_eff;
  logic [7:0]  res_inc;
  logic [27:0] own_off;
  logic [24:0] join_off;
  logic [31:0] uplink_base;
  logic [31:0] period;
  logic [31:0] due_diff;
  logic        dest_hit;
  logic        div_done;
  logic [7:0]  div_rem;

  // Residue of join_seq by the spacing, redone after a spacing write
  tdmans_jdiv u_jdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (every_wr_i),
    .dividend_i (join_seq_q),
    .divisor_i  (every_val_i),
    .busy_o     (busy_o),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Shared offsets and sums
  always_comb begin
    own_off     = 28'(my_slot_q) * 28'(cfg_i.slot_time_us);
    join_off    = 25'(slot_total_q) * 25'(cfg_i.slot_time_us);
    uplink_base = phase_q + 32'(cfg_i.beacon_time_us) + 32'(cfg_i.downlink_time_us);
    period      = 32'(cfg_i.beacon_time_us) + 32'(cfg_i.downlink_time_us)
                + 32'(join_off) + 32'(cfg_i.tail_time_us);
    due_diff    = item_i.now_us - (phase_q + period);
    every_eff   = (cfg_i.join_every == 8'd0) ? 8'd1 : cfg_i.join_every;
    res_inc     = join_res_q + 8'd1;
    dest_hit    = (item_i.dest_index == tdmans_pkg::DEST_BROADCAST)
               || (item_i.dest_index == cfg_i.own_index);
    n_slots     = item_i.payload_last[4:0];
    if (n_slots == 5'd0) begin
      n_slots = 5'd1;
    end else if (n_slots > tdmans_pkg::MAX_SLOTS) begin
      n_slots = tdmans_pkg::MAX_SLOTS;
    end
  end

  // Next state and result
  always_comb begin
    locked_d     = locked_q;
    assigned_d   = assigned_q;
    phase_d      = phase_q;
    frame_cnt_d  = frame_cnt_q;
    slot_total_d = slot_total_q;
    my_slot_d    = my_slot_q;
    bmap_ver_d   = bmap_ver_q;
    held_ver_d   = held_ver_q;
    slot_sent_d  = slot_sent_q;
    join_sent_d  = join_sent_q;
    join_due_d   = join_due_q;
    join_seq_d   = join_seq_q;
    join_res_d   = join_res_q;
    jitter_d     = jitter_q;
    pend_d       = pend_q;
    last_enq_d   = last_enq_q;
    last_bcn_d   = last_bcn_q;
    kind         = tdmans_pkg::TX_NONE;
    at_us        = 32'd0;
    rescan       = 1'b0;
    requested    = 1'b0;

    case (item_i.command)
      tdmans_pkg::CMD_TICK: begin
        if (locked_q) begin
          // Heartbeat queue, saturating
          if ((item_i.now_ms - last_enq_q) >= 32'(cfg_i.heartbeat_period_ms)) begin
            last_enq_d = item_i.now_ms;
            if (pend_q < tdmans_pkg::QUEUE_LIMIT) begin
              pend_d = pend_q + 4'd1;
            end
          end
          // Transmit requests end the tick
          if (assigned_q) begin
            if ((pend_d != 4'd0) && !slot_sent_q) begin
              kind        = tdmans_pkg::TX_HEARTBEAT;
              at_us       = uplink_base + 32'(own_off);
              slot_sent_d = 1'b1;
              requested   = 1'b1;
            end
          end else if (!join_sent_q && join_due_q) begin
            kind        = tdmans_pkg::TX_JOIN;
            at_us       = uplink_base + 32'(join_off) + 32'(jitter_q);
            join_sent_d = 1'b1;
            requested   = 1'b1;
          end
          if (!requested) begin
            if ((last_bcn_q != 32'd0)
                && ((item_i.now_ms - last_bcn_q) > 32'(cfg_i.beacon_lost_ms))) begin
              // Beacon lost
              locked_d   = 1'b0;
              assigned_d = 1'b0;
              my_slot_d  = tdmans_pkg::SLOT_NONE;
              rescan     = 1'b1;
            end else if (!due_diff[31]) begin
              // Free-run to the next nominal superframe
              phase_d     = phase_q + period;
              slot_sent_d = 1'b0;
              join_sent_d = 1'b0;
            end
          end
        end
      end

      tdmans_pkg::CMD_FRAME: begin
        if (item_i.frame_ok) begin
          if (item_i.frame_type == tdmans_pkg::FT_BEACON) begin
            if (!locked_q) begin
              last_enq_d = item_i.now_ms;
            end
            last_bcn_d   = item_i.now_ms;
            phase_d      = item_i.start_us;
            frame_cnt_d  = item_i.payload_word;
            slot_total_d = n_slots;
            bmap_ver_d   = item_i.payload_last[7:5];
            locked_d     = 1'b1;
            slot_sent_d  = 1'b0;
            join_sent_d  = 1'b0;
            join_due_d   = (join_res_q == 8'd0);
            join_seq_d   = join_seq_q + 8'd1;
            // Residue follows the sequence, restarting at its wrap
            if (join_seq_q == 8'hFF || res_inc == every_eff) begin
              join_res_d = 8'd0;
            end else begin
              join_res_d = res_inc;
            end
            jitter_d = item_i.jitter_us;
            if (assigned_q && ({5'd0, item_i.payload_last[7:5]} != held_ver_q)) begin
              assigned_d = 1'b0;
            end
          end else if (dest_hit && (item_i.frame_type == tdmans_pkg::FT_ASSIGN)) begin
            if (item_i.payload_word[23:16] == tdmans_pkg::SLOT_NONE) begin
              // Channel full
              rescan     = 1'b1;
              locked_d   = 1'b0;
              assigned_d = 1'b0;
            end else begin
              assigned_d = 1'b1;
              my_slot_d  = item_i.payload_word[23:16];
              held_ver_d = item_i.payload_word[7:0];
            end
          end
        end
      end

      tdmans_pkg::CMD_TX_RESULT: begin
        if (item_i.tx_ok && (pend_q != 4'd0)) begin
          pend_d = pend_q - 4'd1;
        end
      end

      default: ;
    endcase

    res_o.tx_kind          = kind;
    res_o.tx_at_us         = at_us;
    res_o.is_locked        = locked_d;
    res_o.is_assigned      = assigned_d;
    res_o.slot_number      = my_slot_d;
    res_o.slots_in_frame   = slot_total_d;
    res_o.rescan_request   = rescan;
    res_o.superframe_count = frame_cnt_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q     <= 1'b0;
      assigned_q   <= 1'b0;
      phase_q      <= 32'd0;
      frame_cnt_q  <= 32'd0;
      slot_total_q <= 5'd0;
      my_slot_q    <= tdmans_pkg::SLOT_NONE;
      bmap_ver_q   <= 3'd0;
      held_ver_q   <= 8'd0;
      slot_sent_q  <= 1'b0;
      join_sent_q  <= 1'b0;
      join_due_q   <= 1'b0;
      join_seq_q   <= 8'd0;
      join_res_q   <= 8'd0;
      jitter_q     <= 16'd0;
      pend_q       <= 4'd0;
      last_enq_q   <= 32'd0;
      last_bcn_q   <= 32'd0;
    end else if (fire_i) begin
      locked_q     <= locked_d;
      assigned_q   <= assigned_d;
      phase_q      <= phase_d;
      frame_cnt_q  <= frame_cnt_d;
      slot_total_q <= slot_total_d;
      my_slot_q    <= my_slot_d;
      bmap_ver_q   <= bmap_ver_d;
      held_ver_q   <= held_ver_d;
      slot_sent_q  <= slot_sent_d;
      join_sent_q  <= join_sent_d;
      join_due_q   <= join_due_d;
      join_seq_q   <= join_seq_d;
      join_res_q   <= join_res_d;
      jitter_q     <= jitter_d;
      pend_q       <= pend_d;
      last_enq_q   <= last_enq_d;
      last_bcn_q   <= last_bcn_d;
    end else if (div_done) begin
      join_res_q <= div_rem;
    end
  end

endmodule

[hdl/tdma_node_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// tdma_node_slot_scheduler: node side of a beacon-locked TDMA MAC
// Input register, single-pass step logic and an output register.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle when stalled neither by the output nor by a
//   join residue run; the step is one pass of compare, a 20x8 and a 20x5
//   multiply and add logic between the input and result registers.
// A join_every write recomputes the join residue serially; input stalls from that write until the run is done.
// Reset: asynchronous, active low; clears all state but the payload and divider datapath registers.
module tdma_node_slot_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // in: now_us, now_ms, frame_ok, frame_type, dest_index, payload_word,
  //     payload_last, start_us, jitter_us, tx_ok, zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [167:0]                      s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,   // command
  // out: tx_at_us, is_locked, is_assigned, slot_number, slots_in_frame,
  //      rescan_request, superframe_count
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [79:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,   // tx_kind
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tdmans_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdmans_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tdmans_pkg::cfg_t    cfg;
  tdmans_pkg::item_t   in_item, in_q;
  tdmans_pkg::result_t res, out_q;
  logic in_valid_q, out_valid_q;
  logic advance, s_fire, every_wr, div_busy;

  tdmans_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Unpack the input item
  always_comb begin
    in_item.command      = s_axis_tuser;
    in_item.now_us       = s_axis_tdata[31:0];
    in_item.now_ms       = s_axis_tdata[63:32];
    in_item.frame_ok     = s_axis_tdata[64];
    in_item.frame_type   = s_axis_tdata[66:65];
    in_item.dest_index   = s_axis_tdata[74:67];
    in_item.payload_word = s_axis_tdata[106:75];
    in_item.payload_last = s_axis_tdata[114:107];
    in_item.start_us     = s_axis_tdata[146:115];
    in_item.jitter_us    = s_axis_tdata[162:147];
    in_item.tx_ok        = s_axis_tdata[163];
  end

  // Handshake: step fires when the result register is free or draining
  assign every_wr      = cfg_we_i && (cfg_idx_i == tdmans_pkg::REG_JOIN_EVERY);
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !div_busy && !every_wr && (!in_valid_q || advance);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  tdmans_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (advance),
    .item_i      (in_q),
    .every_wr_i  (every_wr),
    .every_val_i (cfg_wdata_i[7:0]),
    .busy_o      (div_busy),
    .res_o       (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= in_item;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // Pack the result item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.tx_kind;
  assign m_axis_tdata  = {out_q.superframe_count, out_q.rescan_request,
                          out_q.slots_in_frame, out_q.slot_number,
                          out_q.is_assigned, out_q.is_locked, out_q.tx_at_us};

endmodule

[hdl/tdmans_chk.sv]
// ----------------------------------------------------------------------------
// tdmans_chk: port-level checker for the TDMA node slot scheduler
// Watches the result stream for consistency; bound to the top level.
// ----------------------------------------------------------------------------
module tdmans_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // No request carries no target time
  a_no_tx_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tdmans_pkg::TX_NONE)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("tx_at_us nonzero without a request");

  // Slot count stays within the clamp once set
  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[46:42] <= tdmans_pkg::MAX_SLOTS))
    else $error("slots_in_frame above limit");

  // A rescan always comes with lock and assignment dropped
  a_rescan_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[47]) |-> (!m_axis_tdata[32] && !m_axis_tdata[33]))
    else $error("rescan while locked or assigned");

  // Heartbeats only from an assigned locked node, joins only unassigned
  a_request_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != tdmans_pkg::TX_NONE)) |->
      (m_axis_tdata[32] && !m_axis_tdata[47]
       && ((m_axis_tuser == tdmans_pkg::TX_HEARTBEAT && m_axis_tdata[33])
        || (m_axis_tuser == tdmans_pkg::TX_JOIN && !m_axis_tdata[33]))))
    else $error("transmit request in wrong node state");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind tdma_node_slot_scheduler tdmans_chk u_tdmans_chk (.*);
